/* rtl/core/dtf_pkg.sv */
// Shared constants and types for the degenerate triangle filter.
package dtf_pkg;

   localparam int DEF_COORD_BITS = 12;
   localparam int DEF_INDEX_BITS = 16;

   localparam int EPS_W      = 53;
   localparam int VCOUNT_W   = 17;
   localparam int SLOT_W     = 16;
   localparam int CSR_DATA_W = EPS_W;

   localparam logic [EPS_W-1:0]    EPS_RESET    = EPS_W'(1);
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(65536);
   localparam logic [SLOT_W-1:0]   COUNT_MAX    = {SLOT_W{1'b1}};

   typedef enum logic [0:0] {
      CSR_EPS_SQUARE   = 1'b0,
      CSR_VERTEX_COUNT = 1'b1
   } csr_index_type;

endpackage

/* rtl/core/dtf_req_if.sv */
// Triangle request channel: valid/ready with indices and corner coordinates.
interface dtf_req_if #(
   parameter int COORD_BITS = dtf_pkg::DEF_COORD_BITS,
   parameter int INDEX_BITS = dtf_pkg::DEF_INDEX_BITS
);
   logic                         valid;
   logic                         ready;
   logic [INDEX_BITS-1:0]        index_a;
   logic [INDEX_BITS-1:0]        index_b;
   logic [INDEX_BITS-1:0]        index_c;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] az;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by;
   logic signed [COORD_BITS-1:0] bz;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] cz;

   modport source (
      output valid, index_a, index_b, index_c, ax, ay, az, bx, by, bz, cx, cy, cz,
      input  ready
   );
   modport sink (
      input  valid, index_a, index_b, index_c, ax, ay, az, bx, by, bz, cx, cy, cz,
      output ready
   );
endinterface

/* rtl/core/dtf_rsp_if.sv */
// Filter response channel: valid/ready with flags and compacted slot.
interface dtf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        index_error;
   logic                        zero_area;
   logic                        zero_edge;
   logic                        accepted;
   logic [dtf_pkg::SLOT_W-1:0]  slot;

   modport source (
      output valid, index_error, zero_area, zero_edge, accepted, slot,
      input  ready
   );
   modport sink (
      input  valid, index_error, zero_area, zero_edge, accepted, slot,
      output ready
   );
endinterface

/* rtl/core/degenerate_triangle_filter.sv */
// Degenerate triangle filter: top level with control registers.
//
// req_chan carries one triangle per transfer: three vertex indices and the
// three corners as signed fixed-point coordinates. rsp_chan returns one result
// per triangle, in order: index_error, zero_area, zero_edge, accepted and the
// compacted-list slot of an accepted triangle (0 otherwise).
// csr_write_en/csr_index/csr_data write eps_square and vertex_count; write
// them only while no triangle is in flight.
// A request is registered in the queue and then in each back-end stage before
// its result is valid. Throughput: one triangle per cycle while rsp_chan is not
// stalled, set by the four-stage multiply pipeline of the back end; a two-entry
// queue separates index check and edge formation from the arithmetic.
// Reset: eps_square = 1, vertex_count = 65536, slot counter = 0, pipeline
// empty. The slot counter saturates at 65535.
// When rsp_chan.valid is high and rsp_chan.ready is low the back end holds all
// stages; the queue keeps taking up to two triangles, then req_chan.ready drops.
module degenerate_triangle_filter #(
   parameter int COORD_BITS = dtf_pkg::DEF_COORD_BITS,
   parameter int INDEX_BITS = dtf_pkg::DEF_INDEX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  dtf_pkg::csr_index_type         csr_index,
   input  logic [dtf_pkg::CSR_DATA_W-1:0] csr_data,
   dtf_req_if.sink                        req_chan,
   dtf_rsp_if.source                      rsp_chan
);
   import dtf_pkg::*;

   localparam int QW = 9 * (COORD_BITS + 1) + 1;

   logic [EPS_W-1:0]    eps_square_ff;
   logic [VCOUNT_W-1:0] vertex_count_ff;
   logic                push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0]       push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_square_ff   <= EPS_RESET;
         vertex_count_ff <= VCOUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_EPS_SQUARE: begin
               eps_square_ff <= csr_data[EPS_W-1:0];
            end
            CSR_VERTEX_COUNT: begin
               vertex_count_ff <= csr_data[VCOUNT_W-1:0];
            end
         endcase
      end
   end

   dtf_front #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .req_chan     (req_chan),
      .vertex_count (vertex_count_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   dtf_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dtf_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eps_square (eps_square_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_chan   (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_index_error_clears_tests: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.index_error |-> !rsp_chan.zero_area && !rsp_chan.zero_edge)
      else $error("index error reported together with a geometry flag");

   a_accept_means_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.accepted |->
         !rsp_chan.index_error && !rsp_chan.zero_area && !rsp_chan.zero_edge)
      else $error("accepted triangle carries a reject flag");

   a_reject_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.accepted |-> rsp_chan.slot == '0)
      else $error("rejected triangle reports a nonzero slot");

   a_queue_full_blocks: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> pop_valid)
      else $error("queue reports full while empty");
`endif
endmodule

/* rtl/core/dtf_queue.sv */
// Two-entry decoupling queue between the classify front and the math back end.
module dtf_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* rtl/core/dtf_front.sv */
// Front end: takes triangles, checks vertex indices and forms edge vectors.
module dtf_front #(
   parameter int COORD_BITS = dtf_pkg::DEF_COORD_BITS,
   parameter int INDEX_BITS = dtf_pkg::DEF_INDEX_BITS
) (
   dtf_req_if.sink                     req_chan,
   input  logic [dtf_pkg::VCOUNT_W-1:0] vertex_count,
   output logic                        push_valid,
   input  logic                        push_ready,
   output logic [9*(COORD_BITS+1):0]   push_data
);
   import dtf_pkg::*;

   localparam int DW  = COORD_BITS + 1;
   localparam int PAD = VCOUNT_W - INDEX_BITS;

   typedef struct packed {
      logic                 index_error;
      logic signed [DW-1:0] e1x, e1y, e1z;
      logic signed [DW-1:0] e2x, e2y, e2z;
      logic signed [DW-1:0] e3x, e3y, e3z;
   } entry_type;

   entry_type entry;

   always_comb begin
      entry.index_error = ({{PAD{1'b0}}, req_chan.index_a} >= vertex_count) ||
                          ({{PAD{1'b0}}, req_chan.index_b} >= vertex_count) ||
                          ({{PAD{1'b0}}, req_chan.index_c} >= vertex_count);
      // e1 = C - A, e2 = B - A, e3 = C - B
      entry.e1x = {req_chan.cx[COORD_BITS-1], req_chan.cx} -
                  {req_chan.ax[COORD_BITS-1], req_chan.ax};
      entry.e1y = {req_chan.cy[COORD_BITS-1], req_chan.cy} -
                  {req_chan.ay[COORD_BITS-1], req_chan.ay};
      entry.e1z = {req_chan.cz[COORD_BITS-1], req_chan.cz} -
                  {req_chan.az[COORD_BITS-1], req_chan.az};
      entry.e2x = {req_chan.bx[COORD_BITS-1], req_chan.bx} -
                  {req_chan.ax[COORD_BITS-1], req_chan.ax};
      entry.e2y = {req_chan.by[COORD_BITS-1], req_chan.by} -
                  {req_chan.ay[COORD_BITS-1], req_chan.ay};
      entry.e2z = {req_chan.bz[COORD_BITS-1], req_chan.bz} -
                  {req_chan.az[COORD_BITS-1], req_chan.az};
      entry.e3x = {req_chan.cx[COORD_BITS-1], req_chan.cx} -
                  {req_chan.bx[COORD_BITS-1], req_chan.bx};
      entry.e3y = {req_chan.cy[COORD_BITS-1], req_chan.cy} -
                  {req_chan.by[COORD_BITS-1], req_chan.by};
      entry.e3z = {req_chan.cz[COORD_BITS-1], req_chan.cz} -
                  {req_chan.bz[COORD_BITS-1], req_chan.bz};
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_data      = entry;
endmodule

/* rtl/core/dtf_back.sv */
// Back end: cross product, squared lengths, tolerance tests and slot assignment.
module dtf_back #(
   parameter int COORD_BITS = dtf_pkg::DEF_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dtf_pkg::EPS_W-1:0] eps_square,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  logic [9*(COORD_BITS+1):0] pop_data,
   dtf_rsp_if.source                 rsp_chan
);
   import dtf_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int AW = 2 * PW;

   typedef struct packed {
      logic                 index_error;
      logic signed [DW-1:0] e1x, e1y, e1z;
      logic signed [DW-1:0] e2x, e2y, e2z;
      logic signed [DW-1:0] e3x, e3y, e3z;
   } entry_type;

   entry_type q;
   logic      adv;

   // stage 1: products
   logic                 v1_ff, ierr1_ff;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [PW-1:0] prod_in [6];
   logic [PW-1:0]        esq_ff  [9];
   logic [PW-1:0]        esq_in  [9];
   // stage 2: cross components, edge test
   logic                 v2_ff, ierr2_ff, zedge2_ff, zedge2_in;
   logic signed [PW-1:0] cr_ff [3];
   logic [PW-1:0]        lsum_in [3];
   // stage 3: squared cross components
   logic                 v3_ff, ierr3_ff, zedge3_ff;
   logic [AW-1:0]        csq_ff [3];
   // output stage
   logic [AW-1:0]        area_in;
   logic                 zarea_in, acc_in;
   logic [SLOT_W-1:0]    count_ff;
   logic                 rsp_valid_ff, ierr_ff, zarea_ff, zedge_ff, acc_ff;
   logic [SLOT_W-1:0]    slot_ff;

   assign q         = pop_data;
   assign adv       = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = adv;

   always_comb begin
      prod_in[0] = PW'($signed(q.e1y)) * PW'($signed(q.e2z));
      prod_in[1] = PW'($signed(q.e1z)) * PW'($signed(q.e2y));
      prod_in[2] = PW'($signed(q.e1z)) * PW'($signed(q.e2x));
      prod_in[3] = PW'($signed(q.e1x)) * PW'($signed(q.e2z));
      prod_in[4] = PW'($signed(q.e1x)) * PW'($signed(q.e2y));
      prod_in[5] = PW'($signed(q.e1y)) * PW'($signed(q.e2x));
      esq_in[0]  = PW'($signed(q.e2x)) * PW'($signed(q.e2x));
      esq_in[1]  = PW'($signed(q.e2y)) * PW'($signed(q.e2y));
      esq_in[2]  = PW'($signed(q.e2z)) * PW'($signed(q.e2z));
      esq_in[3]  = PW'($signed(q.e3x)) * PW'($signed(q.e3x));
      esq_in[4]  = PW'($signed(q.e3y)) * PW'($signed(q.e3y));
      esq_in[5]  = PW'($signed(q.e3z)) * PW'($signed(q.e3z));
      esq_in[6]  = PW'($signed(q.e1x)) * PW'($signed(q.e1x));
      esq_in[7]  = PW'($signed(q.e1y)) * PW'($signed(q.e1y));
      esq_in[8]  = PW'($signed(q.e1z)) * PW'($signed(q.e1z));
   end

   always_comb begin
      lsum_in[0] = esq_ff[0] + esq_ff[1] + esq_ff[2];
      lsum_in[1] = esq_ff[3] + esq_ff[4] + esq_ff[5];
      lsum_in[2] = esq_ff[6] + esq_ff[7] + esq_ff[8];
      zedge2_in  = ({{(EPS_W-PW){1'b0}}, lsum_in[0]} < eps_square) ||
                   ({{(EPS_W-PW){1'b0}}, lsum_in[1]} < eps_square) ||
                   ({{(EPS_W-PW){1'b0}}, lsum_in[2]} < eps_square);
   end

   always_comb begin
      area_in  = csq_ff[0] + csq_ff[1] + csq_ff[2];
      zarea_in = !ierr3_ff && ({{(EPS_W-AW){1'b0}}, area_in} < eps_square);
      acc_in   = !ierr3_ff && !zarea_in && !zedge3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (adv) begin
         v1_ff        <= pop_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
         if (v3_ff && acc_in && (count_ff != COUNT_MAX)) begin
            count_ff <= count_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ierr1_ff  <= q.index_error;
         prod_ff   <= prod_in;
         esq_ff    <= esq_in;
         ierr2_ff  <= ierr1_ff;
         zedge2_ff <= zedge2_in;
         cr_ff[0]  <= prod_ff[0] - prod_ff[1];
         cr_ff[1]  <= prod_ff[2] - prod_ff[3];
         cr_ff[2]  <= prod_ff[4] - prod_ff[5];
         ierr3_ff  <= ierr2_ff;
         zedge3_ff <= zedge2_ff;
         csq_ff[0] <= AW'(cr_ff[0]) * AW'(cr_ff[0]);
         csq_ff[1] <= AW'(cr_ff[1]) * AW'(cr_ff[1]);
         csq_ff[2] <= AW'(cr_ff[2]) * AW'(cr_ff[2]);
         ierr_ff   <= ierr3_ff;
         zarea_ff  <= zarea_in;
         zedge_ff  <= !ierr3_ff && zedge3_ff;
         acc_ff    <= acc_in;
         slot_ff   <= acc_in ? count_ff : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.index_error = ierr_ff;
   assign rsp_chan.zero_area   = zarea_ff;
   assign rsp_chan.zero_edge   = zedge_ff;
   assign rsp_chan.accepted    = acc_ff;
   assign rsp_chan.slot        = slot_ff;
endmodule
